>>> rtl/core/opwft_pkg.sv
package opwft_pkg;

    localparam int MaxCodeBitsDefault = 32;
    localparam int CodeW              = 32;
    localparam int CodeIdxW           = $clog2(CodeW);
    localparam int BitCntW            = 6;
    localparam int ApbAddrW           = 5;
    localparam int ApbDataW           = 32;

    localparam logic [15:0] PulseUnitReset = 16'd400;
    localparam logic [3:0]  RepeatReset    = 4'd8;
    localparam logic [5:0]  SyncHighReset  = 6'd9;
    localparam logic [5:0]  GapReset       = 6'd30;
    localparam logic [3:0]  LongReset      = 4'd3;

    localparam logic [2:0] RegPulseUnit = 3'd0;
    localparam logic [2:0] RegRepeat    = 3'd1;
    localparam logic [2:0] RegSyncHigh  = 3'd2;
    localparam logic [2:0] RegGap       = 3'd3;
    localparam logic [2:0] RegLong      = 3'd4;

    localparam logic ReqTick  = 1'b0;
    localparam logic ReqStart = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SYNC_HI = 6'b000010,
        PH_SYNC_LO = 6'b000100,
        PH_BIT_HI  = 6'b001000,
        PH_BIT_LO  = 6'b010000,
        PH_GAP     = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [15:0] pulse_unit_ticks;
        logic [3:0]  repeat_count;
        logic [5:0]  sync_high_units;
        logic [5:0]  gap_units;
        logic [3:0]  long_units;
    } cfg_t;

    typedef struct packed {
        logic start_rejected;
        logic busy_res;
        logic line_level;
    } result_t;

endpackage

>>> rtl/core/ook_pulse_width_frame_transmitter.sv
// the result of an accepted request is computed combinationally and captured in the output register
// throughput: one request per cycle, limited only by the single output register stage
// a request is taken while the output register is empty or being drained the same cycle
// reset: synchronous active-low aresetn, sequencer idle, line low, registers to defaults
module ook_pulse_width_frame_transmitter #(
    parameter int MAX_CODE_BITS = opwft_pkg::MaxCodeBitsDefault
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [39:0]                      s_tdata,   // code_word, bit_count, pad
    input  logic                             s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // line_level, busy_res, start_rejected, pad
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [opwft_pkg::ApbAddrW-1:0]   paddr,
    input  logic [opwft_pkg::ApbDataW-1:0]   pwdata,
    output logic [opwft_pkg::ApbDataW-1:0]   prdata,
    output logic                             pready
);

    opwft_pkg::cfg_t    cfg;
    opwft_pkg::result_t result;
    logic               out_ready;
    logic               req_accept;

    assign s_tready   = out_ready;
    assign req_accept = s_tvalid && out_ready;

    opwft_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    opwft_seq #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (req_accept),
        .req_type   (s_tuser),
        .code_word  (s_tdata[31:0]),
        .bit_count  (s_tdata[37:32]),
        .cfg        (cfg),
        .result     (result)
    );

    opwft_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (req_accept),
        .result   (result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> m_tdata[1])
        else $error("rejected start without busy");

    a_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("line high while idle");

    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

endmodule

>>> rtl/core/opwft_cfg.sv
module opwft_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [opwft_pkg::ApbAddrW-1:0]    paddr,
    input  logic [opwft_pkg::ApbDataW-1:0]    pwdata,
    output logic [opwft_pkg::ApbDataW-1:0]    prdata,
    output logic                              pready,
    output opwft_pkg::cfg_t                   cfg
);

    opwft_pkg::cfg_t cfg_reg;
    opwft_pkg::cfg_t cfg_next;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[opwft_pkg::ApbAddrW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                opwft_pkg::RegPulseUnit: cfg_next.pulse_unit_ticks = pwdata[15:0];
                opwft_pkg::RegRepeat:    cfg_next.repeat_count     = pwdata[3:0];
                opwft_pkg::RegSyncHigh:  cfg_next.sync_high_units  = pwdata[5:0];
                opwft_pkg::RegGap:       cfg_next.gap_units        = pwdata[5:0];
                opwft_pkg::RegLong:      cfg_next.long_units       = pwdata[3:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            opwft_pkg::RegPulseUnit: prdata = {16'd0, cfg_reg.pulse_unit_ticks};
            opwft_pkg::RegRepeat:    prdata = {28'd0, cfg_reg.repeat_count};
            opwft_pkg::RegSyncHigh:  prdata = {26'd0, cfg_reg.sync_high_units};
            opwft_pkg::RegGap:       prdata = {26'd0, cfg_reg.gap_units};
            opwft_pkg::RegLong:      prdata = {28'd0, cfg_reg.long_units};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_unit_ticks <= opwft_pkg::PulseUnitReset;
            cfg_reg.repeat_count     <= opwft_pkg::RepeatReset;
            cfg_reg.sync_high_units  <= opwft_pkg::SyncHighReset;
            cfg_reg.gap_units        <= opwft_pkg::GapReset;
            cfg_reg.long_units       <= opwft_pkg::LongReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/opwft_seq.sv
module opwft_seq #(
    parameter int MAX_CODE_BITS = opwft_pkg::MaxCodeBitsDefault
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              req_accept,
    input  logic                              req_type,
    input  logic [opwft_pkg::CodeW-1:0]       code_word,
    input  logic [opwft_pkg::BitCntW-1:0]     bit_count,
    input  opwft_pkg::cfg_t                   cfg,
    output opwft_pkg::result_t                result
);

    localparam logic [opwft_pkg::BitCntW:0] MaxBits = (opwft_pkg::BitCntW+1)'(MAX_CODE_BITS);

    opwft_pkg::phase_t               phase_reg, phase_next;
    logic [opwft_pkg::CodeW-1:0]     shift_word_reg, shift_word_next;
    logic [opwft_pkg::BitCntW-1:0]   bits_in_frame_reg, bits_in_frame_next;
    logic [opwft_pkg::BitCntW-1:0]   bit_position_reg, bit_position_next;
    logic [3:0]                      repeats_left_reg, repeats_left_next;
    logic [5:0]                      units_left_reg, units_left_next;
    logic [15:0]                     ticks_left_reg, ticks_left_next;

    logic [15:0] unit_ticks;
    logic [5:0]  sync_units;
    logic [5:0]  gap_units;
    logic [5:0]  long_units;
    logic [3:0]  repeats;
    logic [15:0] tick_dec;
    logic [5:0]  unit_dec;
    logic [3:0]  repeat_dec;
    logic [opwft_pkg::BitCntW-1:0] pos_first;
    logic [opwft_pkg::BitCntW-1:0] pos_dec;
    logic [opwft_pkg::BitCntW-1:0] n_clamped;
    logic        bit_cur;
    logic        bit_first;
    logic        bit_dec;
    logic        rejected;

    function automatic logic code_bit(input logic [opwft_pkg::CodeW-1:0] word,
                                      input logic [opwft_pkg::BitCntW-1:0] pos);
        logic res;
        if (pos >= opwft_pkg::BitCntW'(opwft_pkg::CodeW)) begin
            res = 1'b0;
        end else begin
            res = word[pos[opwft_pkg::CodeIdxW-1:0]];
        end
        return res;
    endfunction

    // zero registers act as one
    assign unit_ticks = (cfg.pulse_unit_ticks == '0) ? 16'd1 : cfg.pulse_unit_ticks;
    assign sync_units = (cfg.sync_high_units == '0) ? 6'd1 : cfg.sync_high_units;
    assign gap_units  = (cfg.gap_units == '0) ? 6'd1 : cfg.gap_units;
    assign long_units = (cfg.long_units == '0) ? 6'd1 : {2'd0, cfg.long_units};
    assign repeats    = (cfg.repeat_count == '0) ? 4'd1 : cfg.repeat_count;

    assign tick_dec   = ticks_left_reg - 16'd1;
    assign unit_dec   = units_left_reg - 6'd1;
    assign repeat_dec = repeats_left_reg - 4'd1;
    assign pos_first  = bits_in_frame_reg - opwft_pkg::BitCntW'(1);
    assign pos_dec    = bit_position_reg - opwft_pkg::BitCntW'(1);
    assign bit_cur    = code_bit(shift_word_reg, bit_position_reg);
    assign bit_first  = code_bit(shift_word_reg, pos_first);
    assign bit_dec    = code_bit(shift_word_reg, pos_dec);
    assign n_clamped  = ({1'b0, bit_count} > MaxBits) ?
                        MaxBits[opwft_pkg::BitCntW-1:0] : bit_count;

    always_comb begin
        phase_next         = phase_reg;
        shift_word_next    = shift_word_reg;
        bits_in_frame_next = bits_in_frame_reg;
        bit_position_next  = bit_position_reg;
        repeats_left_next  = repeats_left_reg;
        units_left_next    = units_left_reg;
        ticks_left_next    = ticks_left_reg;
        rejected           = 1'b0;
        if (req_accept) begin
            if (req_type == opwft_pkg::ReqStart) begin
                if (phase_reg != opwft_pkg::PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    shift_word_next    = code_word;
                    bits_in_frame_next = n_clamped;
                    bit_position_next  = '0;
                    repeats_left_next  = repeats;
                    phase_next         = opwft_pkg::PH_SYNC_HI;
                    units_left_next    = sync_units;
                    ticks_left_next    = unit_ticks;
                end
            end else if (phase_reg != opwft_pkg::PH_IDLE) begin
                if (tick_dec != '0) begin
                    ticks_left_next = tick_dec;
                end else if (unit_dec != '0) begin
                    units_left_next = unit_dec;
                    ticks_left_next = unit_ticks;
                end else begin
                    // segment done
                    ticks_left_next = unit_ticks;
                    unique case (phase_reg)
                        opwft_pkg::PH_SYNC_HI: begin
                            phase_next      = opwft_pkg::PH_SYNC_LO;
                            units_left_next = 6'd1;
                        end
                        opwft_pkg::PH_SYNC_LO: begin
                            if (bits_in_frame_reg != '0) begin
                                bit_position_next = pos_first;
                                phase_next        = opwft_pkg::PH_BIT_HI;
                                units_left_next   = bit_first ? 6'd1 : long_units;
                            end else begin
                                phase_next      = opwft_pkg::PH_GAP;
                                units_left_next = gap_units;
                            end
                        end
                        opwft_pkg::PH_BIT_HI: begin
                            phase_next      = opwft_pkg::PH_BIT_LO;
                            units_left_next = bit_cur ? long_units : 6'd1;
                        end
                        opwft_pkg::PH_BIT_LO: begin
                            if (bit_position_reg != '0) begin
                                bit_position_next = pos_dec;
                                phase_next        = opwft_pkg::PH_BIT_HI;
                                units_left_next   = bit_dec ? 6'd1 : long_units;
                            end else begin
                                phase_next      = opwft_pkg::PH_GAP;
                                units_left_next = gap_units;
                            end
                        end
                        opwft_pkg::PH_GAP: begin
                            repeats_left_next = repeat_dec;
                            if (repeat_dec != '0) begin
                                phase_next      = opwft_pkg::PH_SYNC_HI;
                                units_left_next = sync_units;
                            end else begin
                                phase_next      = opwft_pkg::PH_IDLE;
                                units_left_next = '0;
                                ticks_left_next = '0;
                            end
                        end
                        default: begin
                            phase_next      = opwft_pkg::PH_IDLE;
                            units_left_next = unit_dec;
                            ticks_left_next = tick_dec;
                        end
                    endcase
                end
            end
        end
    end

    assign result.line_level     = (phase_next == opwft_pkg::PH_SYNC_HI) ||
                                   (phase_next == opwft_pkg::PH_BIT_HI);
    assign result.busy_res       = (phase_next != opwft_pkg::PH_IDLE);
    assign result.start_rejected = rejected;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= opwft_pkg::PH_IDLE;
            shift_word_reg    <= '0;
            bits_in_frame_reg <= '0;
            bit_position_reg  <= '0;
            repeats_left_reg  <= '0;
            units_left_reg    <= '0;
            ticks_left_reg    <= '0;
        end else begin
            phase_reg         <= phase_next;
            shift_word_reg    <= shift_word_next;
            bits_in_frame_reg <= bits_in_frame_next;
            bit_position_reg  <= bit_position_next;
            repeats_left_reg  <= repeats_left_next;
            units_left_reg    <= units_left_next;
            ticks_left_reg    <= ticks_left_next;
        end
    end

endmodule

>>> rtl/core/opwft_out.sv
module opwft_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  opwft_pkg::result_t  result,
    output logic                ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata
);

    logic               valid_reg, valid_next;
    opwft_pkg::result_t data_reg;

    assign ready      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {5'd0, data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import opwft_pkg::*;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 120;

    typedef struct {
        logic        kind;
        logic [31:0] word;
        logic [5:0]  count;
    } tx_request_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata  = '0;  // code_word, bit_count, pad
    logic                s_tuser  = 1'b0;  // req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;  // line_level, busy_res, start_rejected, pad
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ApbAddrW-1:0] paddr    = '0;
    logic [ApbDataW-1:0] pwdata   = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    ook_pulse_width_frame_transmitter dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // encoder state mirror
    cfg_t        enc_cfg   = '{PulseUnitReset, RepeatReset, SyncHighReset, GapReset, LongReset};
    logic [31:0] enc_word  = '0;
    logic [5:0]  enc_bits  = '0;
    logic [5:0]  enc_pos   = '0;
    logic [3:0]  enc_reps  = '0;
    phase_t      enc_phase = PH_IDLE;
    logic [5:0]  enc_units = '0;
    logic [15:0] enc_ticks = '0;

    tx_request_t tx_requests[$];
    tx_request_t in_flight;
    result_t     line_due[$];

    int err_count    = 0;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int hold_left    = 0;
    int stall_cycles = 0;
    int est_left     = 0;
    bit in_taken     = 1'b0;
    bit in_holding   = 1'b0;
    bit no_idle      = 1'b0;
    bit hold_trigger = 1'b0;
    bit hold_done    = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    function automatic logic [15:0] unit_ticks();
        return (enc_cfg.pulse_unit_ticks == 16'd0) ? 16'd1 : enc_cfg.pulse_unit_ticks;
    endfunction

    function automatic logic cur_code_bit();
        return (enc_pos >= 6'd32) ? 1'b0 : enc_word[enc_pos[4:0]];
    endfunction

    function automatic void enc_enter(phase_t ph, logic [5:0] units);
        enc_phase = ph;
        enc_units = (units == 6'd0) ? 6'd1 : units;
        enc_ticks = unit_ticks();
    endfunction

    function automatic void enc_bit_high();
        enc_enter(PH_BIT_HI, cur_code_bit() ? 6'd1 : {2'b00, enc_cfg.long_units});
    endfunction

    function automatic void enc_next_segment();
        case (enc_phase)
            PH_SYNC_HI: enc_enter(PH_SYNC_LO, 6'd1);
            PH_SYNC_LO: begin
                if (enc_bits != 6'd0) begin
                    enc_pos = enc_bits - 6'd1;
                    enc_bit_high();
                end else begin
                    enc_enter(PH_GAP, enc_cfg.gap_units);
                end
            end
            PH_BIT_HI: enc_enter(PH_BIT_LO, cur_code_bit() ? {2'b00, enc_cfg.long_units} : 6'd1);
            PH_BIT_LO: begin
                if (enc_pos != 6'd0) begin
                    enc_pos = enc_pos - 6'd1;
                    enc_bit_high();
                end else begin
                    enc_enter(PH_GAP, enc_cfg.gap_units);
                end
            end
            PH_GAP: begin
                enc_reps = enc_reps - 4'd1;
                if (enc_reps != 4'd0) begin
                    enc_enter(PH_SYNC_HI, enc_cfg.sync_high_units);
                end else begin
                    enc_phase = PH_IDLE;
                    enc_units = '0;
                    enc_ticks = '0;
                end
            end
            default: enc_phase = PH_IDLE;
        endcase
    endfunction

    function automatic result_t encoder_step(tx_request_t rq);
        result_t r;
        r.start_rejected = 1'b0;
        if (rq.kind == ReqStart) begin
            if (enc_phase != PH_IDLE) begin
                r.start_rejected = 1'b1;
            end else begin
                enc_word = rq.word;
                enc_bits = (rq.count > 6'(MaxCodeBitsDefault)) ? 6'(MaxCodeBitsDefault)
                                                               : rq.count;
                enc_pos  = '0;
                enc_reps = (enc_cfg.repeat_count == 4'd0) ? 4'd1 : enc_cfg.repeat_count;
                enc_enter(PH_SYNC_HI, enc_cfg.sync_high_units);
            end
        end else if (enc_phase != PH_IDLE) begin
            enc_ticks = enc_ticks - 16'd1;
            if (enc_ticks == 16'd0) begin
                enc_units = enc_units - 6'd1;
                if (enc_units == 6'd0) begin
                    enc_next_segment();
                end else begin
                    enc_ticks = unit_ticks();
                end
            end
        end
        r.line_level = (enc_phase == PH_SYNC_HI) || (enc_phase == PH_BIT_HI);
        r.busy_res   = (enc_phase != PH_IDLE);
        return r;
    endfunction

    function automatic logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            RegPulseUnit: return {16'd0, enc_cfg.pulse_unit_ticks};
            RegRepeat:    return {28'd0, enc_cfg.repeat_count};
            RegSyncHigh:  return {26'd0, enc_cfg.sync_high_units};
            RegGap:       return {26'd0, enc_cfg.gap_units};
            RegLong:      return {28'd0, enc_cfg.long_units};
            default:      return '0;
        endcase
    endfunction

    function automatic tx_request_t start_req(logic [31:0] word, logic [5:0] count);
        tx_request_t rq;
        rq.kind  = ReqStart;
        rq.word  = word;
        rq.count = count;
        return rq;
    endfunction

    // request driver: accept at rising edge, drive at falling edge
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            line_due.push_back(encoder_step(in_flight));
            in_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (in_taken) begin
            in_holding = 1'b0;
            in_taken   = 1'b0;
        end
        if (!in_holding) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (tx_requests.size() > 0) begin
                in_flight = tx_requests.pop_front();
                s_tuser    <= in_flight.kind;
                s_tdata    <= {2'b00, in_flight.count, in_flight.word};
                in_holding = 1'b1;
                tx_gap     = no_idle ? 0 : $urandom_range(0, 14);
            end
        end
        s_tvalid <= in_holding;
    end

    // result side
    always @(negedge aclk) begin
        if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_tready <= (hold_left == 0);
        end
    end

    always @(posedge aclk) begin
        if (hold_trigger && !hold_done) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (m_tvalid && m_tready) begin
            rx_gap = no_idle ? 0 : $urandom_range(0, 14);
            got = result_t'(m_tdata[2:0]);
            if (line_due.size() == 0) begin
                flag_error($sformatf("unexpected result: line %0b busy %0b rejected %0b",
                                     got.line_level, got.busy_res, got.start_rejected));
            end else begin
                want = line_due.pop_front();
                if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
                    got.start_rejected !== want.start_rejected) begin
                    flag_error($sformatf(
                        "result mismatch: expected line %0b busy %0b rejected %0b, got %0b %0b %0b",
                        want.line_level, want.busy_res, want.start_rejected,
                        got.line_level, got.busy_res, got.start_rejected));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== reg_value(idx))
            flag_error($sformatf("register %0d read %h, expected %h", idx, rd, reg_value(idx)));
    endtask

    task automatic cfg_set(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        case (idx)
            RegPulseUnit: enc_cfg.pulse_unit_ticks = value[15:0];
            RegRepeat:    enc_cfg.repeat_count     = value[3:0];
            RegSyncHigh:  enc_cfg.sync_high_units  = value[5:0];
            RegGap:       enc_cfg.gap_units        = value[5:0];
            RegLong:      enc_cfg.long_units       = value[3:0];
            default: ;
        endcase
        apb_access(1'b1, idx, value, rd);
        check_reg(idx);
    endtask

    task automatic drain();
        while (tx_requests.size() > 0 || in_holding || line_due.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_all(input int pu, input int rep, input int sync, input int gap,
                           input int lng);
        drain();
        cfg_set(RegPulseUnit, 32'(pu));
        cfg_set(RegRepeat, 32'(rep));
        cfg_set(RegSyncHigh, 32'(sync));
        cfg_set(RegGap, 32'(gap));
        cfg_set(RegLong, 32'(lng));
    endtask

    // mostly complete transmissions with random content, plus stray starts while busy
    task automatic queue_traffic(input int n);
        tx_request_t rq;
        logic [31:0] word;
        logic [5:0]  count;
        int          sel;
        int          pu, rep, lng;
        for (int i = 0; i < n; i++) begin
            if ((est_left <= 0 && $urandom_range(0, 2) != 0) || $urandom_range(0, 39) == 0) begin
                sel  = $urandom_range(0, 9);
                word = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom);
                sel  = $urandom_range(0, 19);
                if (sel < 3)       count = 6'd0;
                else if (sel < 5)  count = 6'd32;
                else if (sel < 7)  count = 6'($urandom_range(33, 63));
                else if (sel < 8)  count = 6'($urandom_range(9, 31));
                else               count = 6'($urandom_range(1, 8));
                rq = start_req(word, count);
                if (est_left <= 0) begin
                    pu  = (enc_cfg.pulse_unit_ticks == 0) ? 1 : enc_cfg.pulse_unit_ticks;
                    rep = (enc_cfg.repeat_count == 0) ? 1 : enc_cfg.repeat_count;
                    lng = (enc_cfg.long_units == 0) ? 1 : enc_cfg.long_units;
                    est_left = pu * rep * (enc_cfg.sync_high_units + enc_cfg.gap_units + 2 +
                               ((count > 32) ? 32 : count) * (lng + 1));
                end
            end else begin
                rq.kind  = ReqTick;
                rq.word  = $urandom;
                rq.count = 6'($urandom);
                est_left--;
            end
            tx_requests.push_back(rq);
        end
    endtask

    task automatic queue_ticks(input int n);
        tx_request_t rq;
        for (int i = 0; i < n; i++) begin
            rq.kind  = ReqTick;
            rq.word  = $urandom;
            rq.count = 6'($urandom);
            tx_requests.push_back(rq);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i <= int'(RegLong); i++) check_reg(3'(i));

        // directed: idle tick, short word, start while busy, empty frame, oversized count
        cfg_all(1, 1, 1, 1, 2);
        queue_ticks(1);
        tx_requests.push_back(start_req(32'h0000_0005, 6'd3));
        tx_requests.push_back(start_req(32'hFFFF_FFFF, 6'd8));
        queue_ticks(13);
        tx_requests.push_back(start_req(32'hFFFF_FFFF, 6'd0));
        queue_ticks(3);
        tx_requests.push_back(start_req(32'h0000_0000, 6'd63));

        // zero registers behave as one
        cfg_all(0, 0, 0, 0, 0);
        queue_traffic(50);

        cfg_all(1, 15, 63, 63, 15);
        tx_requests.push_back(start_req(32'hA5A5_5A5A, 6'd32));
        est_left = 1000;
        queue_traffic(50);

        for (int k = 0; k < 8; k++) begin
            cfg_all($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 3),
                    $urandom_range(0, 3), $urandom_range(0, 3));
            if (k == 2) begin
                no_idle      = 1'b1;
                hold_trigger = 1'b1;
            end else begin
                no_idle = 1'b0;
            end
            queue_traffic(60);
        end

        cfg_all(65535, $urandom_range(1, 15), $urandom_range(1, 63), $urandom_range(1, 63),
                $urandom_range(1, 15));
        no_idle = 1'b0;
        est_left = 0;
        queue_traffic(30);

        drain();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/opwft_pkg.sv
rtl/core/opwft_cfg.sv
rtl/core/opwft_seq.sv
rtl/core/opwft_out.sv
rtl/core/ook_pulse_width_frame_transmitter.sv
tb/tb.sv
